[design/cpu6502_instruction_execute_macros.svh]
// Assertion macros shared by the 6502 execute block.
// Included by files that carry concurrent assertions.
`ifndef CPU6502_INSTRUCTION_EXECUTE_MACROS_SVH
`define CPU6502_INSTRUCTION_EXECUTE_MACROS_SVH
// Check that a condition implies a property in the same cycle.
`define C65_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
// Check that a condition implies a property in the next cycle.
`define C65_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`endif

[design/c65x_pkg.sv]
// Shared types and constants for the 6502 instruction execute block.
// No dependencies.
`timescale 1ns / 1ps
package c65x_pkg;
   localparam logic [7:0] FLAG_C = 8'h01;
   localparam logic [7:0] FLAG_Z = 8'h02;
   localparam logic [7:0] FLAG_I = 8'h04;
   localparam logic [7:0] FLAG_D = 8'h08;
   localparam logic [7:0] FLAG_B = 8'h10;
   localparam logic [7:0] FLAG_5 = 8'h20;
   localparam logic [7:0] FLAG_V = 8'h40;
   localparam logic [7:0] FLAG_N = 8'h80;
   localparam logic [7:0] STATUS_RESET = 8'h24;
   localparam logic [7:0] STACK_RESET = 8'hFD;
   localparam logic [0:0] REG_BREAK_VECTOR = 1'b0;

   typedef struct packed {
      logic [7:0] opcode;
      logic [15:0] operand_addr;
      logic [7:0] operand_byte;
      logic accumulator_mode;
      logic [15:0] fetched_pc;
      logic [7:0] pulled_byte;
      logic [15:0] pulled_word;
   } req_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] status;
      logic [7:0] sp;
   } regs_type;

   typedef struct packed {
      regs_type regs;
      logic [15:0] next_pc;
      logic mem_write;
      logic [15:0] mem_write_addr;
      logic [7:0] mem_write_data;
      logic [1:0] push_count;
      logic [23:0] push_bytes;
      logic [1:0] extra_cycles;
   } rsp_type;
endpackage

[design/c65x_exec.sv]
// Combinational execute of one decoded 6502 instruction.
// Depends on c65x_pkg.
`timescale 1ns / 1ps
module c65x_exec (
   input  c65x_pkg::req_type  req,
   input  c65x_pkg::regs_type regs,
   input  logic [15:0]        break_vector,
   output c65x_pkg::rsp_type  rsp
);
   import c65x_pkg::*;

   logic [7:0] op, mb, a, x, y, p, sp, src, v, res;
   logic [8:0] sum;
   logic [7:0] addb;
   logic [1:0] sel;
   logic flag, carry, setzn;
   logic [15:0] ret;

   always_comb begin
      op = req.opcode;
      mb = req.operand_byte;
      a = regs.acc;
      x = regs.x;
      y = regs.y;
      p = regs.status;
      sp = regs.sp;
      carry = p[0];
      rsp = '0;
      rsp.next_pc = req.fetched_pc;
      res = 8'h00;
      setzn = 1'b0;
      addb = (op[7:5] == 3'b111) ? ~mb : mb;
      sum = {1'b0, a} + {1'b0, addb} + {8'h00, carry};
      src = req.accumulator_mode ? a : mb;
      ret = req.fetched_pc - 16'd1;
      sel = op[7:6];
      case (sel)
         2'd0: flag = p[7];
         2'd1: flag = p[6];
         2'd2: flag = p[0];
         default: flag = p[1];
      endcase
      case (op[6:5])
         2'd0: v = {src[6:0], 1'b0};
         2'd1: v = {src[6:0], carry};
         2'd2: v = {1'b0, src[7:1]};
         default: v = {carry, src[7:1]};
      endcase
      if (op[4:0] == 5'h10) begin
         if (flag == op[5]) begin
            rsp.next_pc = req.operand_addr;
            rsp.extra_cycles = (req.fetched_pc[15:8] != req.operand_addr[15:8]) ? 2'd2 : 2'd1;
         end
      end else begin
         case (op) inside
            8'h01, 8'h05, 8'h09, 8'h0D, 8'h11, 8'h15, 8'h19, 8'h1D: begin
               a = a | mb; res = a; setzn = 1'b1;
            end
            8'h21, 8'h25, 8'h29, 8'h2D, 8'h31, 8'h35, 8'h39, 8'h3D: begin
               a = a & mb; res = a; setzn = 1'b1;
            end
            8'h41, 8'h45, 8'h49, 8'h4D, 8'h51, 8'h55, 8'h59, 8'h5D: begin
               a = a ^ mb; res = a; setzn = 1'b1;
            end
            8'h61, 8'h65, 8'h69, 8'h6D, 8'h71, 8'h75, 8'h79, 8'h7D,
            8'hE1, 8'hE5, 8'hE9, 8'hED, 8'hF1, 8'hF5, 8'hF9, 8'hFD, 8'hEB: begin
               p[0] = sum[8];
               p[6] = ~(a[7] ^ addb[7]) & (a[7] ^ sum[7]);
               a = sum[7:0]; res = a; setzn = 1'b1;
            end
            8'hC1, 8'hC5, 8'hC9, 8'hCD, 8'hD1, 8'hD5, 8'hD9, 8'hDD: begin
               res = a - mb; setzn = 1'b1; p[0] = (a >= mb);
            end
            8'hE0, 8'hE4, 8'hEC: begin
               res = x - mb; setzn = 1'b1; p[0] = (x >= mb);
            end
            8'hC0, 8'hC4, 8'hCC: begin
               res = y - mb; setzn = 1'b1; p[0] = (y >= mb);
            end
            8'hA1, 8'hA5, 8'hA9, 8'hAD, 8'hB1, 8'hB5, 8'hB9, 8'hBD: begin
               a = mb; res = mb; setzn = 1'b1;
            end
            8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: begin
               x = mb; res = mb; setzn = 1'b1;
            end
            8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: begin
               y = mb; res = mb; setzn = 1'b1;
            end
            8'h81, 8'h85, 8'h8D, 8'h91, 8'h95, 8'h99, 8'h9D: begin
               rsp.mem_write = 1'b1; rsp.mem_write_addr = req.operand_addr;
               rsp.mem_write_data = a;
            end
            8'h86, 8'h8E, 8'h96: begin
               rsp.mem_write = 1'b1; rsp.mem_write_addr = req.operand_addr;
               rsp.mem_write_data = x;
            end
            8'h84, 8'h8C, 8'h94: begin
               rsp.mem_write = 1'b1; rsp.mem_write_addr = req.operand_addr;
               rsp.mem_write_data = y;
            end
            8'h06, 8'h0A, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2A, 8'h2E, 8'h36, 8'h3E,
            8'h46, 8'h4A, 8'h4E, 8'h56, 8'h5E, 8'h66, 8'h6A, 8'h6E, 8'h76, 8'h7E: begin
               p[0] = op[6] ? src[0] : src[7];
               res = v; setzn = 1'b1;
               if (req.accumulator_mode) begin
                  a = v;
               end else begin
                  rsp.mem_write = 1'b1; rsp.mem_write_addr = req.operand_addr;
                  rsp.mem_write_data = v;
               end
            end
            8'hC6, 8'hCE, 8'hD6, 8'hDE, 8'hE6, 8'hEE, 8'hF6, 8'hFE: begin
               res = op[5] ? mb + 8'd1 : mb - 8'd1; setzn = 1'b1;
               rsp.mem_write = 1'b1; rsp.mem_write_addr = req.operand_addr;
               rsp.mem_write_data = res;
            end
            8'h24, 8'h2C: begin
               p[6] = mb[6]; p[1] = ((mb & a) == 8'h00); p[7] = mb[7];
            end
            8'h00: begin
               rsp.push_count = 2'd3;
               rsp.push_bytes = {p | FLAG_B, req.fetched_pc[7:0], req.fetched_pc[15:8]};
               p = p | FLAG_I;
               rsp.next_pc = break_vector;
            end
            8'h20: begin
               rsp.push_count = 2'd2;
               rsp.push_bytes = {8'h00, ret[7:0], ret[15:8]};
               rsp.next_pc = req.operand_addr;
            end
            8'h4C, 8'h6C: rsp.next_pc = req.operand_addr;
            8'h60: begin
               sp = sp + 8'd2; rsp.next_pc = req.pulled_word + 16'd1;
            end
            8'h40: begin
               sp = sp + 8'd3; p = (req.pulled_byte & ~FLAG_B) | FLAG_5;
               rsp.next_pc = req.pulled_word;
            end
            8'h08: begin
               rsp.push_count = 2'd1; rsp.push_bytes = {16'h0000, p | FLAG_B};
            end
            8'h48: begin
               rsp.push_count = 2'd1; rsp.push_bytes = {16'h0000, a};
            end
            8'h28: begin
               sp = sp + 8'd1; p = (req.pulled_byte & ~FLAG_B) | FLAG_5;
            end
            8'h68: begin
               sp = sp + 8'd1; a = req.pulled_byte; res = a; setzn = 1'b1;
            end
            8'h18: p[0] = 1'b0;
            8'h38: p[0] = 1'b1;
            8'h58: p[2] = 1'b0;
            8'h78: p[2] = 1'b1;
            8'hB8: p[6] = 1'b0;
            8'hD8: p[3] = 1'b0;
            8'hF8: p[3] = 1'b1;
            8'h88: begin y = y - 8'd1; res = y; setzn = 1'b1; end
            8'hC8: begin y = y + 8'd1; res = y; setzn = 1'b1; end
            8'hCA: begin x = x - 8'd1; res = x; setzn = 1'b1; end
            8'hE8: begin x = x + 8'd1; res = x; setzn = 1'b1; end
            8'h8A: begin a = x; res = a; setzn = 1'b1; end
            8'h98: begin a = y; res = a; setzn = 1'b1; end
            8'hA8: begin y = a; res = y; setzn = 1'b1; end
            8'hAA: begin x = a; res = x; setzn = 1'b1; end
            8'h9A: sp = x;
            8'hBA: begin x = sp; res = x; setzn = 1'b1; end
            default: ;
         endcase
      end
      if (setzn) begin
         p[1] = (res == 8'h00);
         p[7] = res[7];
      end
      rsp.regs.acc = a;
      rsp.regs.x = x;
      rsp.regs.y = y;
      rsp.regs.status = p;
      rsp.regs.sp = sp - {6'd0, rsp.push_count};
   end
endmodule

[design/cpu6502_instruction_execute.sv]
// 6502 instruction execute block: one decoded instruction per word, no decimal mode.
// Takes one word per clock, set by the single execute stage and its architectural
// register file, unless an untaken result stalls it; each result appears in the
// cycle after its word is accepted and holds in the output register until taken.
// Depends on c65x_pkg, c65x_exec and the assertion macro header.
`timescale 1ns / 1ps
`include "cpu6502_instruction_execute_macros.svh"
module cpu6502_instruction_execute (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[7:0], operand_addr[23:8], operand_byte[31:24], accumulator_mode[32],
   // fetched_pc[48:33], pulled_byte[56:49], pulled_word[72:57], zero pad
   input  logic [79:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // acc_out, x_out, y_out, status_out, stack_out, next_pc, mem_write,
   // mem_write_addr, mem_write_data, push_count, push_bytes, extra_cycles, zero pad
   output logic [111:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import c65x_pkg::*;

   req_type req;
   regs_type regs_ff, regs_in;
   rsp_type res, rsp_ff;
   logic rsp_valid_ff;
   logic [15:0] brk_ff;
   logic accept, csr_wr, csr_hit;

   assign req = '{opcode: req_tdata[7:0], operand_addr: req_tdata[23:8],
                  operand_byte: req_tdata[31:24], accumulator_mode: req_tdata[32],
                  fetched_pc: req_tdata[48:33], pulled_byte: req_tdata[56:49],
                  pulled_word: req_tdata[72:57]};

   c65x_exec u_exec (.req(req), .regs(regs_ff), .break_vector(brk_ff), .rsp(res));

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;
   assign regs_in = accept ? res.regs : regs_ff;

   assign csr_pready = 1'b1;
   assign csr_hit = (csr_paddr[2] == REG_BREAK_VECTOR) && (csr_paddr[1:0] == 2'b00);
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign csr_prdata = csr_hit ? {16'h0000, brk_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '{acc: 8'h00, x: 8'h00, y: 8'h00, status: STATUS_RESET, sp: STACK_RESET};
         rsp_valid_ff <= 1'b0;
         brk_ff <= 16'h0000;
      end else begin
         regs_ff <= regs_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr) begin
            brk_ff <= csr_pwdata[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'd0, rsp_ff.extra_cycles, rsp_ff.push_bytes, rsp_ff.push_count,
                       rsp_ff.mem_write_data, rsp_ff.mem_write_addr, rsp_ff.mem_write,
                       rsp_ff.next_pc, rsp_ff.regs.sp, rsp_ff.regs.status,
                       rsp_ff.regs.y, rsp_ff.regs.x, rsp_ff.regs.acc};

   `C65_ASSERT_NEXT(a_valid_after_accept, clock, reset, accept, rsp_valid_ff)
   `C65_ASSERT_NEXT(a_hold_regs, clock, reset, !accept, $stable(regs_ff))
   `C65_ASSERT_IMP(a_out_matches_regs, clock, reset, rsp_valid_ff, rsp_ff.regs == regs_ff)
   `C65_ASSERT_IMP(a_no_write_no_addr, clock, reset, rsp_valid_ff && !rsp_ff.mem_write,
                   rsp_ff.mem_write_addr == 16'h0000)
endmodule

[bench/tb_cpu6502_instruction_execute.sv]
// Self-checking bench for the 6502 instruction execute block.
// Predicts registers, PC, memory write and stack pushes per word; depends on c65x_pkg.
`timescale 1ns / 1ps
module tb_cpu6502_instruction_execute;
   import c65x_pkg::*;

   localparam int NUM_RANDOM = 1750;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // opcode, operand_addr, operand_byte, accumulator_mode, fetched_pc,
   // pulled_byte, pulled_word, zero pad
   logic [79:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // acc_out, x_out, y_out, status_out, stack_out, next_pc, mem_write,
   // mem_write_addr, mem_write_data, push_count, push_bytes, extra_cycles, zero pad
   logic [111:0] rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   typedef struct {
      logic [7:0]  acc, x, y, status, sp;
      logic [15:0] next_pc;
      logic        mem_write;
      logic [15:0] mem_write_addr;
      logic [7:0]  mem_write_data;
      logic [1:0]  push_count;
      logic [23:0] push_bytes;
      logic [1:0]  extra_cycles;
   } exec_result_type;

   typedef struct {
      logic [7:0]  opcode;
      logic [15:0] operand_addr;
      logic [7:0]  operand_byte;
      logic        accumulator_mode;
      logic [15:0] fetched_pc;
      logic [7:0]  pulled_byte;
      logic [15:0] pulled_word;
   } instr_type;

   instr_type       instr_queue[$];
   exec_result_type expected_results[$];
   int              error_count = 0;
   bit              hold_off_req = 1'b0;
   bit              stimulus_done = 1'b0;

   // predictor copy of the architectural state
   logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_p, cpu_s;
   logic [15:0] brk_vector;

   cpu6502_instruction_execute i_dut (.*);

   always #4 clock = ~clock;

   function automatic logic [79:0] pack_instr(instr_type it);
      return {7'd0, it.pulled_word, it.pulled_byte, it.fetched_pc, it.accumulator_mode,
              it.operand_byte, it.operand_addr, it.opcode};
   endfunction

   function automatic void update_zn(logic [7:0] v);
      cpu_p[1] = (v == 8'h00);
      cpu_p[7] = v[7];
   endfunction

   function automatic void add_carry(logic [7:0] b);
      logic [8:0] sum;
      sum = {1'b0, cpu_a} + {1'b0, b} + {8'h00, cpu_p[0]};
      cpu_p[0] = sum[8];
      cpu_p[6] = ~(cpu_a[7] ^ b[7]) & (cpu_a[7] ^ sum[7]);
      cpu_a = sum[7:0];
      update_zn(cpu_a);
   endfunction

   function automatic void compare_reg(logic [7:0] r, logic [7:0] b);
      update_zn(r - b);
      cpu_p[0] = (r >= b);
   endfunction

   function automatic exec_result_type execute_instr(instr_type it);
      exec_result_type r;
      logic [7:0]  src, v, mask;
      logic        carry_in;
      logic [15:0] ret;
      logic [1:0]  kind;
      r = '{default: '0};
      r.next_pc = it.fetched_pc;
      carry_in = cpu_p[0];
      if (it.opcode[4:0] == 5'h10) begin
         case (it.opcode[7:6])
            2'd0: mask = FLAG_N;
            2'd1: mask = FLAG_V;
            2'd2: mask = FLAG_C;
            default: mask = FLAG_Z;
         endcase
         if (((cpu_p & mask) != 8'h00) == it.opcode[5]) begin
            r.next_pc = it.operand_addr;
            r.extra_cycles = (it.fetched_pc[15:8] != it.operand_addr[15:8]) ? 2'd2 : 2'd1;
         end
      end else begin
         case (it.opcode)
            8'h01, 8'h05, 8'h09, 8'h0D, 8'h11, 8'h15, 8'h19, 8'h1D: begin
               cpu_a |= it.operand_byte; update_zn(cpu_a);
            end
            8'h21, 8'h25, 8'h29, 8'h2D, 8'h31, 8'h35, 8'h39, 8'h3D: begin
               cpu_a &= it.operand_byte; update_zn(cpu_a);
            end
            8'h41, 8'h45, 8'h49, 8'h4D, 8'h51, 8'h55, 8'h59, 8'h5D: begin
               cpu_a ^= it.operand_byte; update_zn(cpu_a);
            end
            8'h61, 8'h65, 8'h69, 8'h6D, 8'h71, 8'h75, 8'h79, 8'h7D: add_carry(it.operand_byte);
            8'hE1, 8'hE5, 8'hE9, 8'hED, 8'hF1, 8'hF5, 8'hF9, 8'hFD, 8'hEB:
               add_carry(~it.operand_byte);
            8'hC1, 8'hC5, 8'hC9, 8'hCD, 8'hD1, 8'hD5, 8'hD9, 8'hDD:
               compare_reg(cpu_a, it.operand_byte);
            8'hE0, 8'hE4, 8'hEC: compare_reg(cpu_x, it.operand_byte);
            8'hC0, 8'hC4, 8'hCC: compare_reg(cpu_y, it.operand_byte);
            8'hA1, 8'hA5, 8'hA9, 8'hAD, 8'hB1, 8'hB5, 8'hB9, 8'hBD: begin
               cpu_a = it.operand_byte; update_zn(cpu_a);
            end
            8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: begin
               cpu_x = it.operand_byte; update_zn(cpu_x);
            end
            8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: begin
               cpu_y = it.operand_byte; update_zn(cpu_y);
            end
            8'h81, 8'h85, 8'h8D, 8'h91, 8'h95, 8'h99, 8'h9D: begin
               r.mem_write = 1'b1; r.mem_write_addr = it.operand_addr;
               r.mem_write_data = cpu_a;
            end
            8'h86, 8'h8E, 8'h96: begin
               r.mem_write = 1'b1; r.mem_write_addr = it.operand_addr;
               r.mem_write_data = cpu_x;
            end
            8'h84, 8'h8C, 8'h94: begin
               r.mem_write = 1'b1; r.mem_write_addr = it.operand_addr;
               r.mem_write_data = cpu_y;
            end
            8'h06, 8'h0A, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2A, 8'h2E, 8'h36, 8'h3E,
            8'h46, 8'h4A, 8'h4E, 8'h56, 8'h5E, 8'h66, 8'h6A, 8'h6E, 8'h76, 8'h7E: begin
               src = it.accumulator_mode ? cpu_a : it.operand_byte;
               kind = it.opcode[6:5];
               case (kind)
                  2'd0: begin cpu_p[0] = src[7]; v = {src[6:0], 1'b0}; end
                  2'd1: begin cpu_p[0] = src[7]; v = {src[6:0], carry_in}; end
                  2'd2: begin cpu_p[0] = src[0]; v = {1'b0, src[7:1]}; end
                  default: begin cpu_p[0] = src[0]; v = {carry_in, src[7:1]}; end
               endcase
               update_zn(v);
               if (it.accumulator_mode) cpu_a = v;
               else begin
                  r.mem_write = 1'b1; r.mem_write_addr = it.operand_addr;
                  r.mem_write_data = v;
               end
            end
            8'hC6, 8'hCE, 8'hD6, 8'hDE, 8'hE6, 8'hEE, 8'hF6, 8'hFE: begin
               v = it.opcode[5] ? it.operand_byte + 8'd1 : it.operand_byte - 8'd1;
               r.mem_write = 1'b1; r.mem_write_addr = it.operand_addr; r.mem_write_data = v;
               update_zn(v);
            end
            8'h24, 8'h2C: begin
               cpu_p[6] = it.operand_byte[6];
               cpu_p[1] = ((it.operand_byte & cpu_a) == 8'h00);
               cpu_p[7] = it.operand_byte[7];
            end
            8'h00: begin
               r.push_count = 2'd3;
               r.push_bytes = {cpu_p | FLAG_B, it.fetched_pc[7:0], it.fetched_pc[15:8]};
               cpu_p |= FLAG_I;
               r.next_pc = brk_vector;
            end
            8'h20: begin
               ret = it.fetched_pc - 16'd1;
               r.push_count = 2'd2;
               r.push_bytes = {8'h00, ret[7:0], ret[15:8]};
               r.next_pc = it.operand_addr;
            end
            8'h4C, 8'h6C: r.next_pc = it.operand_addr;
            8'h60: begin cpu_s += 8'd2; r.next_pc = it.pulled_word + 16'd1; end
            8'h40: begin
               cpu_s += 8'd3;
               cpu_p = (it.pulled_byte & ~FLAG_B) | FLAG_5;
               r.next_pc = it.pulled_word;
            end
            8'h08: begin r.push_count = 2'd1; r.push_bytes = {16'h0, cpu_p | FLAG_B}; end
            8'h48: begin r.push_count = 2'd1; r.push_bytes = {16'h0, cpu_a}; end
            8'h28: begin cpu_s += 8'd1; cpu_p = (it.pulled_byte & ~FLAG_B) | FLAG_5; end
            8'h68: begin cpu_s += 8'd1; cpu_a = it.pulled_byte; update_zn(cpu_a); end
            8'h18: cpu_p[0] = 1'b0;
            8'h38: cpu_p[0] = 1'b1;
            8'h58: cpu_p[2] = 1'b0;
            8'h78: cpu_p[2] = 1'b1;
            8'hB8: cpu_p[6] = 1'b0;
            8'hD8: cpu_p[3] = 1'b0;
            8'hF8: cpu_p[3] = 1'b1;
            8'h88: begin cpu_y -= 8'd1; update_zn(cpu_y); end
            8'hC8: begin cpu_y += 8'd1; update_zn(cpu_y); end
            8'hCA: begin cpu_x -= 8'd1; update_zn(cpu_x); end
            8'hE8: begin cpu_x += 8'd1; update_zn(cpu_x); end
            8'h8A: begin cpu_a = cpu_x; update_zn(cpu_a); end
            8'h98: begin cpu_a = cpu_y; update_zn(cpu_a); end
            8'hA8: begin cpu_y = cpu_a; update_zn(cpu_y); end
            8'hAA: begin cpu_x = cpu_a; update_zn(cpu_x); end
            8'h9A: cpu_s = cpu_x;
            8'hBA: begin cpu_x = cpu_s; update_zn(cpu_x); end
            default: ;
         endcase
      end
      cpu_s = cpu_s - {6'd0, r.push_count};
      r.acc = cpu_a; r.x = cpu_x; r.y = cpu_y; r.status = cpu_p; r.sp = cpu_s;
      return r;
   endfunction

   function automatic instr_type random_instr(logic [7:0] op);
      instr_type it;
      it.opcode = op;
      it.operand_addr = 16'($urandom_range(0, 65535));
      it.operand_byte = ($urandom_range(0, 7) == 0) ? 8'h00 :
                        ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
      it.accumulator_mode = 1'($urandom_range(0, 1));
      it.fetched_pc = 16'($urandom_range(0, 65535));
      // keep some branch targets on the same page
      if ($urandom_range(0, 1) != 0) it.operand_addr[15:8] = it.fetched_pc[15:8];
      it.pulled_byte = 8'($urandom_range(0, 255));
      it.pulled_word = 16'($urandom_range(0, 65535));
      return it;
   endfunction

   task automatic push_instr(instr_type it);
      instr_queue.push_back(it);
      expected_results.push_back(execute_instr(it));
   endtask

   task automatic write_break_vector(logic [15:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {REG_BREAK_VECTOR, 2'b00}; csr_pwdata <= {16'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      brk_vector = value;
   endtask

   task automatic wait_drained();
      while (instr_queue.size() != 0 || expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // driver: one word per handshake, random gaps; the offered word stays at the
   // queue front until it is taken
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_tready) begin
         // hold the offered word
      end else begin
         if (req_tvalid) void'(instr_queue.pop_front());
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (instr_queue.size() > 0) begin
            req_tdata <= pack_instr(instr_queue[0]);
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               req_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver back-pressure, with one long hold-off on request
   int rsp_stall = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_req) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 200;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: compare each taken word with the oldest prediction
   always @(posedge clock) begin
      exec_result_type e;
      rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tdata[31:24],
                rsp_tdata[39:32], rsp_tdata[55:40], rsp_tdata[56], rsp_tdata[72:57],
                rsp_tdata[80:73], rsp_tdata[82:81], rsp_tdata[106:83], rsp_tdata[108:107]};
         if (expected_results.size() == 0) begin
            $error("result word with no prediction pending");
            error_count++;
         end else begin
            e = expected_results.pop_front();
            if (got.regs.acc !== e.acc) begin
               $error("acc_out expected %h actual %h", e.acc, got.regs.acc); error_count++;
            end
            if (got.regs.x !== e.x) begin
               $error("x_out expected %h actual %h", e.x, got.regs.x); error_count++;
            end
            if (got.regs.y !== e.y) begin
               $error("y_out expected %h actual %h", e.y, got.regs.y); error_count++;
            end
            if (got.regs.status !== e.status) begin
               $error("status_out expected %h actual %h", e.status, got.regs.status);
               error_count++;
            end
            if (got.regs.sp !== e.sp) begin
               $error("stack_out expected %h actual %h", e.sp, got.regs.sp); error_count++;
            end
            if (got.next_pc !== e.next_pc) begin
               $error("next_pc expected %h actual %h", e.next_pc, got.next_pc); error_count++;
            end
            if (got.mem_write !== e.mem_write) begin
               $error("mem_write expected %h actual %h", e.mem_write, got.mem_write);
               error_count++;
            end
            if (got.mem_write_addr !== e.mem_write_addr) begin
               $error("mem_write_addr expected %h actual %h", e.mem_write_addr,
                      got.mem_write_addr);
               error_count++;
            end
            if (got.mem_write_data !== e.mem_write_data) begin
               $error("mem_write_data expected %h actual %h", e.mem_write_data,
                      got.mem_write_data);
               error_count++;
            end
            if (got.push_count !== e.push_count) begin
               $error("push_count expected %h actual %h", e.push_count, got.push_count);
               error_count++;
            end
            if (got.push_bytes !== e.push_bytes) begin
               $error("push_bytes expected %h actual %h", e.push_bytes, got.push_bytes);
               error_count++;
            end
            if (got.extra_cycles !== e.extra_cycles) begin
               $error("extra_cycles expected %h actual %h", e.extra_cycles,
                      got.extra_cycles);
               error_count++;
            end
         end
      end
   end

   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      instr_type it;
      logic [7:0] directed_ops[$];
      logic [15:0] vectors[4];
      int hold_cycles;
      cpu_a = 8'h00; cpu_x = 8'h00; cpu_y = 8'h00; cpu_p = STATUS_RESET; cpu_s = STACK_RESET;
      brk_vector = 16'h0000;
      vectors = '{16'hFFFF, 16'h8000, 16'h0000, 16'h1234};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, carry/overflow, stack ops, BRK, undefined and 0xEB, 0x32 vs 0x35
      write_break_vector(16'hC000);
      directed_ops = '{8'hA9, 8'h69, 8'h69, 8'hE9, 8'hEB, 8'h35, 8'h32, 8'h0A, 8'h6A,
                       8'h24, 8'hC9, 8'h00, 8'h20, 8'h60, 8'h40, 8'h08, 8'h48, 8'h28,
                       8'h68, 8'h9A, 8'hBA, 8'hF0, 8'hD0, 8'h02, 8'hFF};
      foreach (directed_ops[i]) begin
         it = random_instr(directed_ops[i]);
         if (i == 0) it.operand_byte = 8'h7F;
         if (i == 1) it.operand_byte = 8'h01;
         if (i == 2) it.operand_byte = 8'hFF;
         if (i == 13) it.pulled_word = 16'hFFFF;
         push_instr(it);
      end
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         write_break_vector(vectors[phase]);
         for (int n = 0; n < NUM_RANDOM / 4; n++) begin
            it = random_instr(8'($urandom_range(0, 255)));
            push_instr(it);
            // let the driver catch up so the queue stays short
            if (instr_queue.size() > 8) @(posedge clock);
            while (instr_queue.size() > 8) @(posedge clock);
            if (phase == 1 && n == 100) begin
               // hold the request until the receiver has seen it at a clock edge
               hold_off_req = 1'b1;
               repeat (2) @(posedge clock);
               hold_off_req = 1'b0;
            end
         end
         wait_drained();
      end
      hold_cycles = 0;
      while (expected_results.size() != 0 && hold_cycles < 10000) begin
         @(posedge clock);
         hold_cycles++;
      end
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
